// ===== sv/hme_pkg.sv =====
package hme_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC      = 16;
    localparam int COEF_W    = DATA_W - 1;
    // Dividend is the Hall coefficient shifted up by the fraction bits.
    localparam int DVD_W     = COEF_W + FRAC;
    localparam int DIV_STEPS = DVD_W;
    localparam int REM_W     = COEF_W + 1;
    // Motional plus resistive sum, and the final wide sum.
    localparam int MS_W      = 2 * DATA_W + 1 - FRAC + 1;
    localparam int SUM_W     = MS_W + 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIFF_W    = PROD_W + 1;

    localparam logic REG_RESISTIVITY = 1'b0;
    localparam logic REG_HALL_COEF   = 1'b1;

    // State of one restoring division step.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        logic [COEF_W-1:0] rho;
    } div_t;

    // Per-item data that rides alongside the divider.
    typedef struct packed {
        logic [MS_W-1:0]   ms_x;
        logic [MS_W-1:0]   ms_y;
        logic [MS_W-1:0]   ms_z;
        logic [DATA_W-1:0] hc_x;
        logic [DATA_W-1:0] hc_y;
        logic [DATA_W-1:0] hc_z;
        logic              clip;
        logic              zero;
    } pay_t;

    // Saturate a wide signed value to the data range; top bit is the clip flag.
    function automatic logic [DATA_W:0] sat_data(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic [DATA_W:0]         r;
        hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (x > hi)
            r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        else if (x < lo)
            r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, x[DATA_W-1:0]};
        return r;
    endfunction

endpackage

// ===== sv/hme_front.sv =====
module hme_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [hme_pkg::COEF_W-1:0]         rho,
    input  logic [hme_pkg::DATA_W-1:0]         vx,
    input  logic [hme_pkg::DATA_W-1:0]         vy,
    input  logic [hme_pkg::DATA_W-1:0]         vz,
    input  logic [hme_pkg::DATA_W-1:0]         bx,
    input  logic [hme_pkg::DATA_W-1:0]         by,
    input  logic [hme_pkg::DATA_W-1:0]         bz,
    input  logic [hme_pkg::DATA_W-1:0]         jx,
    input  logic [hme_pkg::DATA_W-1:0]         jy,
    input  logic [hme_pkg::DATA_W-1:0]         jz,
    input  logic [hme_pkg::COEF_W-1:0]         eta,
    input  logic [hme_pkg::COEF_W-1:0]         di,
    output logic                               out_valid,
    output hme_pkg::div_t                      out_div,
    output hme_pkg::pay_t                      out_pay
);

    localparam int NPROD = 15;

    logic                                valid1_reg;
    logic signed [hme_pkg::PROD_W-1:0]   prod_reg [NPROD];
    logic signed [hme_pkg::PROD_W-1:0]   prod_next [NPROD];
    logic [hme_pkg::COEF_W-1:0]          rho_reg;
    logic [hme_pkg::COEF_W-1:0]          di_reg;
    logic                                valid2_reg;
    hme_pkg::div_t                       div_reg;
    hme_pkg::div_t                       div_next;
    hme_pkg::pay_t                       pay_reg;
    hme_pkg::pay_t                       pay_next;

    // Stage one: every product of the three terms in parallel.
    always_comb
    begin
        prod_next[0]  = $signed(vz) * $signed(by);
        prod_next[1]  = $signed(vy) * $signed(bz);
        prod_next[2]  = $signed(vx) * $signed(bz);
        prod_next[3]  = $signed(vz) * $signed(bx);
        prod_next[4]  = $signed(vy) * $signed(bx);
        prod_next[5]  = $signed(vx) * $signed(by);
        prod_next[6]  = $signed(jy) * $signed(bz);
        prod_next[7]  = $signed(jz) * $signed(by);
        prod_next[8]  = $signed(jz) * $signed(bx);
        prod_next[9]  = $signed(jx) * $signed(bz);
        prod_next[10] = $signed(jx) * $signed(by);
        prod_next[11] = $signed(jy) * $signed(bx);
        prod_next[12] = $signed({1'b0, eta}) * $signed(jx);
        prod_next[13] = $signed({1'b0, eta}) * $signed(jy);
        prod_next[14] = $signed({1'b0, eta}) * $signed(jz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPROD; i++)
                prod_reg[i] <= prod_next[i];
            rho_reg <= rho;
            di_reg  <= di;
            div_reg <= div_next;
            pay_reg <= pay_next;
        end
    end

    // Stage two: cross differences, floor rescale, clip the Hall cross product.
    always_comb
    begin
        logic signed [hme_pkg::DIFF_W-1:0] d [6];
        logic signed [hme_pkg::SUM_W-1:0]  mot [3];
        logic signed [hme_pkg::SUM_W-1:0]  res [3];
        logic signed [hme_pkg::SUM_W-1:0]  ms [3];
        logic [hme_pkg::DATA_W:0]          hs [3];
        for (int i = 0; i < 6; i++)
            d[i] = $signed({prod_reg[2*i][hme_pkg::PROD_W-1], prod_reg[2*i]})
                 - $signed({prod_reg[2*i+1][hme_pkg::PROD_W-1], prod_reg[2*i+1]});
        for (int i = 0; i < 3; i++)
        begin
            mot[i] = hme_pkg::SUM_W'($signed(d[i][hme_pkg::DIFF_W-1:hme_pkg::FRAC]));
            res[i] = hme_pkg::SUM_W'($signed(prod_reg[12+i][hme_pkg::PROD_W-1:hme_pkg::FRAC]));
            ms[i]  = mot[i] + res[i];
            hs[i]  = hme_pkg::sat_data(
                         hme_pkg::SUM_W'($signed(d[3+i][hme_pkg::DIFF_W-1:hme_pkg::FRAC])));
        end
        pay_next.ms_x = ms[0][hme_pkg::MS_W-1:0];
        pay_next.ms_y = ms[1][hme_pkg::MS_W-1:0];
        pay_next.ms_z = ms[2][hme_pkg::MS_W-1:0];
        pay_next.hc_x = hs[0][hme_pkg::DATA_W-1:0];
        pay_next.hc_y = hs[1][hme_pkg::DATA_W-1:0];
        pay_next.hc_z = hs[2][hme_pkg::DATA_W-1:0];
        pay_next.zero = (rho_reg == '0);
        pay_next.clip = !pay_next.zero
                      && (hs[0][hme_pkg::DATA_W] || hs[1][hme_pkg::DATA_W]
                          || hs[2][hme_pkg::DATA_W]);
        div_next.rem = '0;
        div_next.dvd = {di_reg, {hme_pkg::FRAC{1'b0}}};
        div_next.quo = '0;
        div_next.rho = rho_reg;
    end

    assign out_valid = valid2_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== sv/hme_div_cell.sv =====
module hme_div_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  hme_pkg::div_t  in_div,
    input  hme_pkg::pay_t  in_pay,
    output logic           out_valid,
    output hme_pkg::div_t  out_div,
    output hme_pkg::pay_t  out_pay
);

    logic          valid_reg;
    hme_pkg::div_t div_reg;
    hme_pkg::div_t div_next;
    hme_pkg::pay_t pay_reg;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        logic [hme_pkg::REM_W-1:0] tmp;
        logic                      qbit;
        tmp  = {in_div.rem[hme_pkg::REM_W-2:0], in_div.dvd[hme_pkg::DVD_W-1]};
        qbit = (tmp >= {1'b0, in_div.rho});
        div_next.rem = qbit ? tmp - {1'b0, in_div.rho} : tmp;
        div_next.dvd = {in_div.dvd[hme_pkg::DVD_W-2:0], 1'b0};
        div_next.quo = {in_div.quo[hme_pkg::DVD_W-2:0], qbit};
        div_next.rho = in_div.rho;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== sv/hall_mhd_electric_field.sv =====
// Electric field from the generalised Ohm's law, E = -v x B + eta*J + (di/rho)*(J x B),
// in signed Q16.16 with saturation. One grid point is taken per clock cycle unless the
// output holds, and its result passes the front stages, the row of 47 one-bit division
// cells that form di/rho, the Hall multiply and the output register. The whole pipeline
// holds while a result waits untaken. A zero density drops the Hall term and raises
// zero_density; any saturation raises clipped, save in the Hall path at zero density.
// Write resistivity (index 0) and hall_coef (index 1) only while no point is in flight.
module hall_mhd_electric_field
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [hme_pkg::COEF_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // density, vel_x, vel_y, vel_z, mag_x, mag_y, mag_z, cur_x, cur_y, cur_z, zero pad
    input  logic [319:0]                s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // efield_x, efield_y, efield_z
    output logic [95:0]                 m_tdata,
    // zero_density, clipped
    output logic [1:0]                  m_tuser
);

    localparam int NS = hme_pkg::DIV_STEPS;
    localparam int DW = hme_pkg::DATA_W;
    localparam int CW = hme_pkg::COEF_W;

    logic [CW-1:0]  eta_reg;
    logic [CW-1:0]  di_reg;
    logic           en;
    logic           chain_valid [NS+1];
    hme_pkg::div_t  chain_div [NS+1];
    hme_pkg::pay_t  chain_pay [NS+1];
    logic           valid3_reg;
    logic signed [hme_pkg::PROD_W-1:0] hp_reg [3];
    hme_pkg::pay_t  pay3_reg;
    logic           clip3_reg;
    logic           out_valid_reg;
    logic [95:0]    out_data_reg;
    logic [95:0]    out_data_next;
    logic [1:0]     out_user_reg;
    logic [1:0]     out_user_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg <= '0;
            di_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hme_pkg::REG_RESISTIVITY: eta_reg <= cfg_data;
                hme_pkg::REG_HALL_COEF:   di_reg  <= cfg_data;
                default:                  eta_reg <= eta_reg;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being emptied.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    hme_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .rho       (s_tdata[CW-1:0]),
        .vx        (s_tdata[CW+0*DW +: DW]),
        .vy        (s_tdata[CW+1*DW +: DW]),
        .vz        (s_tdata[CW+2*DW +: DW]),
        .bx        (s_tdata[CW+3*DW +: DW]),
        .by        (s_tdata[CW+4*DW +: DW]),
        .bz        (s_tdata[CW+5*DW +: DW]),
        .jx        (s_tdata[CW+6*DW +: DW]),
        .jy        (s_tdata[CW+7*DW +: DW]),
        .jz        (s_tdata[CW+8*DW +: DW]),
        .eta       (eta_reg),
        .di        (di_reg),
        .out_valid (chain_valid[0]),
        .out_div   (chain_div[0]),
        .out_pay   (chain_pay[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar g = 0; g < NS; g++)
    begin : g_div
        hme_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_div    (chain_div[g]),
            .in_pay    (chain_pay[g]),
            .out_valid (chain_valid[g+1]),
            .out_div   (chain_div[g+1]),
            .out_pay   (chain_pay[g+1])
        );
    end

    // Hall multiply by the saturated ratio.
    always_ff @(posedge clk)
    begin
        logic [CW-1:0] q;
        logic          qsat;
        if (en)
        begin
            qsat = |chain_div[NS].quo[hme_pkg::DVD_W-1:CW];
            q    = qsat ? {CW{1'b1}} : chain_div[NS].quo[CW-1:0];
            if (chain_pay[NS].zero)
                q = '0;
            hp_reg[0] <= $signed({1'b0, q}) * $signed(chain_pay[NS].hc_x);
            hp_reg[1] <= $signed({1'b0, q}) * $signed(chain_pay[NS].hc_y);
            hp_reg[2] <= $signed({1'b0, q}) * $signed(chain_pay[NS].hc_z);
            pay3_reg  <= chain_pay[NS];
            clip3_reg <= chain_pay[NS].clip || (qsat && !chain_pay[NS].zero);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid3_reg    <= chain_valid[NS];
            out_valid_reg <= valid3_reg;
        end
    end

    // Final sum and saturation into the output register.
    always_comb
    begin
        logic signed [hme_pkg::SUM_W-1:0] s [3];
        logic [DW:0]                      r [3];
        s[0] = hme_pkg::SUM_W'($signed(pay3_reg.ms_x))
             + hme_pkg::SUM_W'($signed(hp_reg[0][hme_pkg::PROD_W-1:hme_pkg::FRAC]));
        s[1] = hme_pkg::SUM_W'($signed(pay3_reg.ms_y))
             + hme_pkg::SUM_W'($signed(hp_reg[1][hme_pkg::PROD_W-1:hme_pkg::FRAC]));
        s[2] = hme_pkg::SUM_W'($signed(pay3_reg.ms_z))
             + hme_pkg::SUM_W'($signed(hp_reg[2][hme_pkg::PROD_W-1:hme_pkg::FRAC]));
        for (int i = 0; i < 3; i++)
            r[i] = hme_pkg::sat_data(s[i]);
        out_data_next = {r[2][DW-1:0], r[1][DW-1:0], r[0][DW-1:0]};
        out_user_next = {clip3_reg || r[0][DW] || r[1][DW] || r[2][DW], pay3_reg.zero};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
